// ===== rtl/core/bafp_pkg.sv =====
// Shared types and constants for the bitmap atlas first-fit placer.
// Holds the command/status codes, the sequencer states and the beat structs.
// No dependencies.
package bafp_pkg;

  localparam int unsigned WORD_BITS = 64;
  localparam int unsigned WORD_MSB = 63;

  localparam int unsigned ATLAS_WIDTH_BITS_DEF = 1024;
  localparam int unsigned ATLAS_ROWS_DEF = 1024;
  localparam int unsigned MASK_WIDTH_BITS_DEF = 256;
  localparam int unsigned MASK_ROWS_DEF = 256;

  localparam logic [10:0] ATLAS_WIDTH_RESET = 11'd1024;

  // Register index taken from the address bit above the word offset.
  localparam logic REG_ATLAS_WIDTH = 1'b0;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_PLACE = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [1:0] STAT_PLACED = 2'd0;
  localparam logic [1:0] STAT_ROWS = 2'd1;
  localparam logic [1:0] STAT_WIDE = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_ROW,
    ST_RD,
    ST_CK0,
    ST_CK1,
    ST_FINAL,
    ST_SRD,
    ST_SW0,
    ST_SW1
  } state_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  mask_row;
    logic [1:0]  mask_word_index;
    logic [63:0] word_bits;
    logic [8:0]  mask_width;
    logic [8:0]  mask_height;
  } place_in_t;

  typedef struct packed {
    logic [9:0] place_x;
    logic [9:0] place_y;
    logic [1:0] status;
  } place_out_t;

endpackage

// ===== rtl/core/bafp_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Used for the atlas bitmap and the shape mask. No dependencies.
module bafp_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/bitmap_atlas_first_fit_placer.sv =====
// Bitmap atlas first-fit placer: a sequencer drives one shared mask shifter and word
// compare over the atlas and mask RAMs (bafp_ram), using bafp_pkg. Load: no busy time.
// A too-wide place answers in the next cycle. A place visits ST_ROW per offset tried,
// ST_RD, ST_CK0, ST_CK1 per mask word compared there, then ST_FINAL and ST_SRD, ST_SW0,
// ST_SW1 per mask word stamped. Clear zeroes used_height*ATLAS_WIDTH_BITS/64 words; reset
// starts a clearing pass of the whole atlas, busy high. done strobes; no receiver stall.
module bitmap_atlas_first_fit_placer #(
  parameter int unsigned ATLAS_WIDTH_BITS = bafp_pkg::ATLAS_WIDTH_BITS_DEF,
  parameter int unsigned ATLAS_ROWS = bafp_pkg::ATLAS_ROWS_DEF,
  parameter int unsigned MASK_WIDTH_BITS = bafp_pkg::MASK_WIDTH_BITS_DEF,
  parameter int unsigned MASK_ROWS = bafp_pkg::MASK_ROWS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  bafp_pkg::place_in_t    item,
  output logic                   done,
  output bafp_pkg::place_out_t   result,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  import bafp_pkg::*;

  localparam int unsigned AWORDS = ATLAS_WIDTH_BITS / 64;
  localparam int unsigned MWORDS = MASK_WIDTH_BITS / 64;
  localparam int unsigned ADEPTH = ATLAS_ROWS * AWORDS;
  localparam int unsigned MDEPTH = MASK_ROWS * MWORDS;
  localparam int unsigned AAW = $clog2(ADEPTH);
  localparam int unsigned MAW = $clog2(MDEPTH);
  localparam int unsigned AWW = $clog2(ATLAS_WIDTH_BITS + 1);
  localparam int unsigned YW = $clog2(ATLAS_ROWS + 1);
  localparam int unsigned WW = $clog2(MASK_WIDTH_BITS + 1);
  localparam int unsigned HW = $clog2(MASK_ROWS + 1);
  localparam int unsigned CW = $clog2(MWORDS + 1);

  state_t state, state_next;

  logic [10:0]    row_width;
  logic [YW-1:0]  used_height;
  logic [YW-1:0]  search_start_row;
  logic [9:0]     last_size_sum;
  logic [AAW:0]   clr_cnt;
  logic [AAW:0]   clr_end;
  logic [AWW-1:0] x;
  logic [AWW-1:0] xmax;
  logic [YW-1:0]  y;
  logic [WW-1:0]  w;
  logic [HW-1:0]  h;
  logic [HW-1:0]  my;
  logic [CW-1:0]  c;
  logic [CW-1:0]  nch;
  logic           hit0;

  logic           accept;
  logic           cfg_wr;
  logic [AWW-1:0] aw_c;
  logic [WW-1:0]  w_c;
  logic [HW-1:0]  h_c;
  logic           wide_c;
  logic [9:0]     sum_c;
  logic [31:0]    row_c;
  logic [31:0]    i_c;
  logic [31:0]    vld_c;
  logic [31:0]    py_end_c;
  logic           iv0;
  logic           iv1;
  logic           row_ok;
  logic           last_c;
  logic           x_last;
  logic [5:0]     bo;
  logic [63:0]    m_masked;
  logic [63:0]    sh_out;
  logic           sh_left;
  logic           hit1;
  logic [AAW-1:0] addr_i;
  logic [AAW-1:0] addr_i1;

  logic           a_we;
  logic [AAW-1:0] a_waddr;
  logic [63:0]    a_wdata;
  logic [AAW-1:0] a_raddr;
  logic [63:0]    a_q;
  logic           m_we;
  logic [MAW-1:0] m_waddr;
  logic [MAW-1:0] m_raddr;
  logic [63:0]    m_q;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_ATLAS_WIDTH);
  assign prdata = (paddr[2] == REG_ATLAS_WIDTH) ? 32'(row_width) : 32'd0;

  assign accept = start && !busy;

  // Clamp the register and the shape size to the legal ranges.
  assign aw_c = (row_width == 11'd0) ? AWW'(1) :
                (32'(row_width) > ATLAS_WIDTH_BITS) ? AWW'(ATLAS_WIDTH_BITS) :
                AWW'(row_width);
  assign w_c = (item.mask_width == 9'd0) ? WW'(1) :
               (32'(item.mask_width) > MASK_WIDTH_BITS) ? WW'(MASK_WIDTH_BITS) :
               WW'(item.mask_width);
  assign h_c = (item.mask_height == 9'd0) ? HW'(1) :
               (32'(item.mask_height) > MASK_ROWS) ? HW'(MASK_ROWS) :
               HW'(item.mask_height);
  assign wide_c = 32'(w_c) > 32'(aw_c);
  assign sum_c = 10'(32'(w_c) + 32'(h_c));

  assign row_c = 32'(y) + 32'(my);
  assign i_c = 32'(x >> 6) + 32'(c);
  assign iv0 = i_c < AWORDS;
  assign iv1 = (i_c + 32'd1) < AWORDS;
  assign addr_i = AAW'(row_c * AWORDS + i_c);
  assign addr_i1 = AAW'(row_c * AWORDS + i_c + 32'd1);
  assign row_ok = (my < h) && (row_c < 32'(used_height));
  assign last_c = (c == nch - CW'(1));
  assign x_last = (x == xmax);
  assign bo = x[5:0];
  assign py_end_c = 32'(y) + 32'(h);

  // Mask bits at or beyond the shape width are ignored.
  assign vld_c = 32'(w) - 32'(c) * 32'(WORD_BITS);
  assign m_masked = (vld_c < WORD_BITS) ?
                    (m_q & ((64'd1 << vld_c[5:0]) - 64'd1)) : m_q;

  // Shared shifter: the left part lands in word i, the spill in word i+1.
  assign sh_out = sh_left ? (m_masked << bo) :
                  (m_masked >> (7'(WORD_MSB + 1) - {1'b0, bo}));
  assign hit1 = (bo != 6'd0) && iv1 && ((a_q & sh_out) != 64'd0);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && item.cmd == CMD_CLEAR) begin
          state_next = ST_CLEAR;
        end else if (accept && item.cmd == CMD_PLACE && !wide_c) begin
          state_next = ST_ROW;
        end
      end
      ST_CLEAR: begin
        if (clr_cnt == clr_end - (AAW + 1)'(1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_ROW:   state_next = (y < used_height) ? ST_RD : ST_FINAL;
      ST_RD:    state_next = row_ok ? ST_CK0 : ST_FINAL;
      ST_CK0:   state_next = ST_CK1;
      ST_CK1:   state_next = (hit0 || hit1) ? ST_ROW : ST_RD;
      ST_FINAL: state_next = (py_end_c > ATLAS_ROWS) ? ST_IDLE : ST_SRD;
      ST_SRD:   state_next = (my < h) ? ST_SW0 : ST_IDLE;
      ST_SW0:   state_next = ST_SW1;
      ST_SW1:   state_next = ST_SRD;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy = (state != ST_IDLE);
    a_we = 1'b0;
    a_waddr = addr_i;
    a_wdata = a_q | sh_out;
    a_raddr = addr_i;
    sh_left = 1'b1;
    m_we = accept && (item.cmd == CMD_LOAD) && (32'(item.mask_row) < MASK_ROWS) &&
           (32'(item.mask_word_index) < MWORDS);
    m_waddr = MAW'(32'(item.mask_row) * MWORDS + 32'(item.mask_word_index));
    m_raddr = MAW'(32'(my) * MWORDS + 32'(c));
    unique case (state)
      ST_CLEAR: begin
        a_we = 1'b1;
        a_waddr = clr_cnt[AAW-1:0];
        a_wdata = 64'd0;
      end
      ST_CK0: begin
        a_raddr = addr_i1;
      end
      ST_CK1: begin
        sh_left = 1'b0;
      end
      ST_SW0: begin
        a_we = iv0;
        a_raddr = addr_i1;
      end
      ST_SW1: begin
        sh_left = 1'b0;
        a_we = (bo != 6'd0) && iv1;
        a_waddr = addr_i1;
      end
      default: begin
        a_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      done <= 1'b0;
      row_width <= ATLAS_WIDTH_RESET;
      used_height <= YW'(1);
      search_start_row <= '0;
      last_size_sum <= '0;
      clr_cnt <= '0;
      clr_end <= (AAW + 1)'(ADEPTH);
    end else begin
      state <= state_next;
      done <= 1'b0;
      if (cfg_wr) begin
        row_width <= pwdata[10:0];
      end
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + (AAW + 1)'(1);
      end
      if (state == ST_IDLE && accept && item.cmd == CMD_CLEAR) begin
        clr_cnt <= '0;
        clr_end <= (AAW + 1)'(32'(used_height) * AWORDS);
        used_height <= YW'(1);
        search_start_row <= '0;
        last_size_sum <= '0;
      end
      if (state == ST_IDLE && accept && item.cmd == CMD_PLACE) begin
        if (wide_c) begin
          done <= 1'b1;
        end else if (sum_c != last_size_sum) begin
          search_start_row <= '0;
          last_size_sum <= sum_c;
        end
      end
      if (state == ST_FINAL) begin
        if (py_end_c > ATLAS_ROWS) begin
          done <= 1'b1;
        end else begin
          if (py_end_c > 32'(used_height)) begin
            used_height <= YW'(py_end_c);
          end
          search_start_row <= y;
        end
      end
      if (state == ST_SRD && !(my < h)) begin
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        w <= w_c;
        h <= h_c;
        nch <= CW'((32'(w_c) + 32'd63) >> 6);
        xmax <= aw_c - AWW'(w_c);
        x <= '0;
        y <= (sum_c != last_size_sum) ? '0 : search_start_row;
        if (wide_c) begin
          result <= '{place_x: 10'd0, place_y: 10'd0, status: STAT_WIDE};
        end
      end
      ST_ROW: begin
        my <= '0;
        c <= '0;
      end
      ST_CK0: begin
        hit0 <= iv0 && ((a_q & sh_out) != 64'd0);
      end
      ST_CK1: begin
        if (hit0 || hit1) begin
          if (x_last) begin
            x <= '0;
            y <= y + YW'(1);
          end else begin
            x <= x + AWW'(1);
          end
        end else if (last_c) begin
          c <= '0;
          my <= my + HW'(1);
        end else begin
          c <= c + CW'(1);
        end
      end
      ST_FINAL: begin
        my <= '0;
        c <= '0;
        if (py_end_c > ATLAS_ROWS) begin
          result <= '{place_x: 10'd0, place_y: 10'd0, status: STAT_ROWS};
        end
      end
      ST_SRD: begin
        if (!(my < h)) begin
          result <= '{place_x: 10'(x), place_y: 10'(y), status: STAT_PLACED};
        end
      end
      ST_SW1: begin
        if (last_c) begin
          c <= '0;
          my <= my + HW'(1);
        end else begin
          c <= c + CW'(1);
        end
      end
      default: begin
        hit0 <= hit0;
      end
    endcase
  end

  bafp_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(ADEPTH)
  ) u_atlas_ram (
    .clk  (clk),
    .we   (a_we),
    .waddr(a_waddr),
    .wdata(a_wdata),
    .raddr(a_raddr),
    .rdata(a_q)
  );

  bafp_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(MDEPTH)
  ) u_mask_ram (
    .clk  (clk),
    .we   (m_we),
    .waddr(m_waddr),
    .wdata(item.word_bits),
    .raddr(m_raddr),
    .rdata(m_q)
  );

  // A rejected shape reports the origin as its position.
  a_reject_origin: assert property (@(posedge clk) disable iff (rst)
    done && result.status != STAT_PLACED |-> result.place_x == 10'd0 &&
    result.place_y == 10'd0)
    else $error("rejected beat carries a nonzero position");

  // The used height stays between one row and the row store.
  a_height_range: assert property (@(posedge clk) disable iff (rst)
    used_height != '0 && 32'(used_height) <= ATLAS_ROWS)
    else $error("used height out of range");

  // The search never starts at or above the used height.
  a_start_below: assert property (@(posedge clk) disable iff (rst)
    search_start_row < used_height)
    else $error("search start row past used height");

  // The clearing sweep only ever writes zero words.
  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> a_we && a_wdata == 64'd0)
    else $error("clearing sweep wrote a nonzero word");

  // No result comes out while a sweep is still running.
  a_no_done_clear: assert property (@(posedge clk) disable iff (rst)
    $past(state) == ST_CLEAR |-> !done)
    else $error("result during clearing sweep");

endmodule
